@@ design/sdsq_pkg.sv @@
// sd spi host sequencer package: phases, status codes, command codes, result struct
// no dependencies
package sdsq_pkg;

  localparam int BLOCK_BYTES_DEF = 512;
  localparam int BUSY_POLL_LIMIT_DEF = 255;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_BYTE  = 2'd3;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TIMEOUT   = 4'd1;
  localparam logic [3:0] ST_NO_IDLE   = 4'd2;
  localparam logic [3:0] ST_UNKNOWN   = 4'd3;
  localparam logic [3:0] ST_ACMD_FAIL = 4'd4;
  localparam logic [3:0] ST_CMD58     = 4'd5;
  localparam logic [3:0] ST_UNSUPP    = 4'd6;
  localparam logic [3:0] ST_BLOCK     = 4'd7;
  localparam logic [3:0] ST_WR_REJECT = 4'd8;
  localparam logic [3:0] ST_WR_STATUS = 4'd9;

  localparam logic [1:0] CARD_NONE = 2'd0;
  localparam logic [1:0] CARD_SD1  = 2'd1;
  localparam logic [1:0] CARD_SD2  = 2'd2;
  localparam logic [1:0] CARD_SDHC = 2'd3;

  localparam logic [5:0] CMD0  = 6'd0;
  localparam logic [5:0] CMD8  = 6'd8;
  localparam logic [5:0] CMD13 = 6'd13;
  localparam logic [5:0] CMD17 = 6'd17;
  localparam logic [5:0] CMD24 = 6'd24;
  localparam logic [5:0] CMD55 = 6'd55;
  localparam logic [5:0] CMD58 = 6'd58;
  localparam logic [5:0] ACMD41 = 6'h29;

  typedef enum logic [13:0] {
    PH_IDLE       = 14'b00000000000001,
    PH_CMD_READY  = 14'b00000000000010,
    PH_CMD_SEND   = 14'b00000000000100,
    PH_CMD_RESP   = 14'b00000000001000,
    PH_R7_TAIL    = 14'b00000000010000,
    PH_OCR        = 14'b00000000100000,
    PH_TOKEN_WAIT = 14'b00000001000000,
    PH_READ_DATA  = 14'b00000010000000,
    PH_WR_TOKEN   = 14'b00000100000000,
    PH_WR_DATA    = 14'b00001000000000,
    PH_WR_CRC     = 14'b00010000000000,
    PH_WR_RESP    = 14'b00100000000000,
    PH_WR_BUSY    = 14'b01000000000000,
    PH_CMD13_TAIL = 14'b10000000000000
  } phase_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        is_req;
    logic [1:0]  opcode;
    logic        do_init;
    logic [31:0] block_address;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic       transfer_request;
    logic [7:0] tx_byte;
    logic       link_init;
    logic       write_byte_taken;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [3:0] status;
    logic [1:0] card_type;
  } result_t;

endpackage

@@ design/sdsq_front.sv @@
// front end: accepts request and byte beats, classifies them, holds a two-entry queue
// depends on sdsq_pkg
module sdsq_front import sdsq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [31:0] block_address,
  input  logic        link_timed_out,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  write_byte,
  output logic        item_valid,
  output item_t       item,
  input  logic        item_take
);

  item_t      q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  item_t      incoming;

  always_comb begin
    incoming.is_req        = (opcode != OP_BYTE);
    incoming.opcode        = opcode;
    incoming.do_init       = (opcode == OP_INIT) || link_timed_out;
    incoming.block_address = block_address;
    incoming.rx_byte       = rx_byte;
    incoming.write_byte    = write_byte;
  end

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];

  logic do_push, do_pop;
  assign do_push = push && !full;
  assign do_pop  = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= incoming;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ design/sdsq_back.sv @@
// back end: sequencer state machine plus output queue of results
// depends on sdsq_pkg
module sdsq_back import sdsq_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int BUSY_POLL_LIMIT = BUSY_POLL_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_take,
  output logic        res_valid,
  output result_t     res,
  input  logic        res_take
);

  localparam logic [15:0] BLK = 16'(BLOCK_BYTES);
  localparam logic [15:0] BPL = 16'(BUSY_POLL_LIMIT);

  logic [15:0] timeout_limit;
  phase_t      phase, phase_next;
  logic [15:0] byte_counter, byte_counter_next;
  logic [15:0] retry_counter, retry_counter_next;
  logic [47:0] command_shift, command_shift_next;
  logic [5:0]  current_command, current_command_next;
  logic [1:0]  pending_request, pending_request_next;
  logic [31:0] saved_address, saved_address_next;
  logic [1:0]  card_kind, card_kind_next;
  logic [3:0]  last_error, last_error_next;
  result_t     r;

  // output queue
  result_t    oq [2];
  logic       owr, ord;
  logic [1:0] ocount;

  assign item_take = item_valid && (ocount != 2'd2);
  assign res_valid = (ocount != 2'd0);
  assign res       = oq[ord];

  logic [15:0] bc_sat;
  assign bc_sat = (byte_counter != 16'hFFFF) ? byte_counter + 16'd1 : byte_counter;

  always_comb begin
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic        go_cmd, go_rw, go_init_done, go_fin, go_acmd;
    logic [3:0]  fin_code;
    logic [7:0]  rx;
    logic [7:0]  crc;
    logic [15:0] rc;
    phase_next           = phase;
    byte_counter_next    = byte_counter;
    retry_counter_next   = retry_counter;
    command_shift_next   = command_shift;
    current_command_next = current_command;
    pending_request_next = pending_request;
    saved_address_next   = saved_address;
    card_kind_next       = card_kind;
    last_error_next      = last_error;
    cmd = CMD0; arg = 32'd0;
    go_cmd = 1'b0; go_rw = 1'b0; go_init_done = 1'b0; go_fin = 1'b0; go_acmd = 1'b0;
    fin_code = ST_OK;
    rx = item.rx_byte;
    crc = 8'hFF;
    rc = 16'd0;
    r = '0;
    r.tx_byte = 8'hFF;

    if (item.is_req) begin
      last_error_next      = ST_OK;
      byte_counter_next    = 16'd0;
      retry_counter_next   = 16'd0;
      pending_request_next = item.opcode;
      saved_address_next   = item.block_address;
      if (item.do_init) begin
        r.link_init = 1'b1;
        go_cmd = 1'b1; cmd = CMD0;
      end else begin
        go_rw = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_IDLE: ;
        PH_CMD_READY: begin
          if (rx == 8'hFF) begin
            phase_next = PH_CMD_SEND;
            byte_counter_next = 16'd0;
            r.transfer_request = 1'b1; r.tx_byte = command_shift[47:40];
          end else begin
            byte_counter_next = bc_sat;
            if (bc_sat >= timeout_limit) begin go_fin = 1'b1; fin_code = ST_TIMEOUT; end
            else r.transfer_request = 1'b1;
          end
        end
        PH_CMD_SEND: begin
          byte_counter_next = byte_counter + 16'd1;
          if (byte_counter_next < 16'd6) begin
            r.transfer_request = 1'b1;
            case (byte_counter_next[2:0])
              3'd1: r.tx_byte = command_shift[39:32];
              3'd2: r.tx_byte = command_shift[31:24];
              3'd3: r.tx_byte = command_shift[23:16];
              3'd4: r.tx_byte = command_shift[15:8];
              default: r.tx_byte = command_shift[7:0];
            endcase
          end else begin
            phase_next = PH_CMD_RESP; byte_counter_next = 16'd0;
            r.transfer_request = 1'b1;
          end
        end
        PH_CMD_RESP: begin
          logic hit;
          hit = 1'b0;
          if (rx[7]) begin
            byte_counter_next = bc_sat;
            hit = (bc_sat >= BPL);
          end
          if (!rx[7] || hit) begin
            case (current_command)
              CMD0: if (rx == 8'h01) begin go_cmd = 1'b1; cmd = CMD8; arg = 32'h1AA; end
                    else begin go_fin = 1'b1; fin_code = ST_NO_IDLE; end
              CMD8: if (rx[2]) begin card_kind_next = CARD_SD1; go_acmd = 1'b1; end
                    else begin
                      phase_next = PH_R7_TAIL; byte_counter_next = 16'd0;
                      r.transfer_request = 1'b1;
                    end
              CMD55: begin
                go_cmd = 1'b1; cmd = ACMD41;
                arg = (card_kind == CARD_SD2) ? 32'h40000000 : 32'd0;
              end
              ACMD41: begin
                if (rx == 8'h00) begin
                  if (card_kind == CARD_SD2) begin go_cmd = 1'b1; cmd = CMD58; end
                  else go_init_done = 1'b1;
                end else begin
                  rc = (retry_counter != 16'hFFFF) ? retry_counter + 16'd1 : retry_counter;
                  retry_counter_next = rc;
                  if (rc >= timeout_limit) begin go_fin = 1'b1; fin_code = ST_ACMD_FAIL; end
                  else begin go_cmd = 1'b1; cmd = CMD55; end
                end
              end
              CMD58: if (rx != 8'h00) begin go_fin = 1'b1; fin_code = ST_CMD58; end
                     else begin
                       phase_next = PH_OCR; byte_counter_next = 16'd0;
                       r.transfer_request = 1'b1;
                     end
              CMD17: if (rx != 8'h00) begin go_fin = 1'b1; fin_code = ST_BLOCK; end
                     else begin
                       phase_next = PH_TOKEN_WAIT; byte_counter_next = 16'd0;
                       r.transfer_request = 1'b1;
                     end
              CMD24: if (rx != 8'h00) begin go_fin = 1'b1; fin_code = ST_BLOCK; end
                     else begin
                       phase_next = PH_WR_TOKEN;
                       r.transfer_request = 1'b1; r.tx_byte = 8'hFE;
                     end
              default: if (rx != 8'h00) begin go_fin = 1'b1; fin_code = ST_WR_STATUS; end
                       else begin
                         phase_next = PH_CMD13_TAIL; r.transfer_request = 1'b1;
                       end
            endcase
          end else begin
            r.transfer_request = 1'b1;
          end
        end
        PH_R7_TAIL: begin
          byte_counter_next = byte_counter + 16'd1;
          if (byte_counter_next < 16'd4) r.transfer_request = 1'b1;
          else if (rx != 8'hAA) begin go_fin = 1'b1; fin_code = ST_UNKNOWN; end
          else begin card_kind_next = CARD_SD2; go_acmd = 1'b1; end
        end
        PH_OCR: begin
          byte_counter_next = byte_counter + 16'd1;
          if (byte_counter_next == 16'd1 && rx[7:6] == 2'b11) card_kind_next = CARD_SDHC;
          if (byte_counter_next < 16'd4) r.transfer_request = 1'b1;
          else go_init_done = 1'b1;
        end
        PH_TOKEN_WAIT: begin
          if (rx == 8'hFF) begin
            byte_counter_next = bc_sat;
            if (bc_sat >= timeout_limit) begin go_fin = 1'b1; fin_code = ST_TIMEOUT; end
            else r.transfer_request = 1'b1;
          end else if (rx != 8'hFE) begin go_fin = 1'b1; fin_code = ST_BLOCK; end
          else begin
            phase_next = PH_READ_DATA; byte_counter_next = 16'd0;
            r.transfer_request = 1'b1;
          end
        end
        PH_READ_DATA: begin
          r.read_valid = 1'b1; r.read_byte = rx;
          byte_counter_next = byte_counter + 16'd1;
          if (byte_counter_next >= BLK) begin go_fin = 1'b1; fin_code = ST_OK; end
          else r.transfer_request = 1'b1;
        end
        PH_WR_TOKEN: begin
          phase_next = PH_WR_DATA; byte_counter_next = 16'd0;
          r.transfer_request = 1'b1; r.tx_byte = item.write_byte;
          r.write_byte_taken = 1'b1;
        end
        PH_WR_DATA: begin
          byte_counter_next = byte_counter + 16'd1;
          r.transfer_request = 1'b1;
          if (byte_counter_next < BLK) begin
            r.tx_byte = item.write_byte; r.write_byte_taken = 1'b1;
          end else begin
            phase_next = PH_WR_CRC; byte_counter_next = 16'd0;
          end
        end
        PH_WR_CRC: begin
          byte_counter_next = byte_counter + 16'd1;
          if (byte_counter_next >= 16'd2) phase_next = PH_WR_RESP;
          r.transfer_request = 1'b1;
        end
        PH_WR_RESP: begin
          if (rx[4:0] != 5'h05) begin go_fin = 1'b1; fin_code = ST_WR_REJECT; end
          else begin
            phase_next = PH_WR_BUSY; byte_counter_next = 16'd0;
            r.transfer_request = 1'b1;
          end
        end
        PH_WR_BUSY: begin
          if (rx == 8'h00) begin
            byte_counter_next = bc_sat;
            if (bc_sat >= timeout_limit) begin go_fin = 1'b1; fin_code = ST_TIMEOUT; end
            else r.transfer_request = 1'b1;
          end else begin go_cmd = 1'b1; cmd = CMD13; end
        end
        PH_CMD13_TAIL: begin
          go_fin = 1'b1;
          fin_code = (rx != 8'h00) ? ST_WR_STATUS : ST_OK;
        end
        default: ;
      endcase
    end

    if (go_acmd) begin
      retry_counter_next = 16'd0;
      go_cmd = 1'b1; cmd = CMD55;
    end
    // init finished: continue into the read/write when one was asked for
    if (go_init_done) begin
      if (pending_request == OP_READ || pending_request == OP_WRITE) go_rw = 1'b1;
      else begin go_fin = 1'b1; fin_code = ST_OK; end
    end
    if (go_rw) begin
      if (card_kind_next != CARD_SDHC) begin go_fin = 1'b1; fin_code = ST_UNSUPP; end
      else begin
        go_cmd = 1'b1;
        cmd = (pending_request_next == OP_READ) ? CMD17 : CMD24;
        arg = saved_address_next;
      end
    end
    if (go_cmd) begin
      if (cmd == CMD0) crc = 8'h95;
      else if (cmd == CMD8) crc = 8'h87;
      command_shift_next   = {2'b01, cmd, arg, crc};
      current_command_next = cmd;
      byte_counter_next    = 16'd0;
      phase_next           = PH_CMD_READY;
      r.transfer_request   = 1'b1;
      r.tx_byte            = 8'hFF;
    end
    if (go_fin) begin
      last_error_next    = fin_code;
      phase_next         = PH_IDLE;
      r.transfer_request = 1'b0;
      r.tx_byte          = 8'hFF;
      r.done_res         = 1'b1;
    end
    r.status    = last_error_next;
    r.card_type = card_kind_next;
  end

  logic opush, opop;
  assign opush = item_take;
  assign opop  = res_take && res_valid;

  always_ff @(posedge clk) begin
    if (opush) oq[owr] <= r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit   <= TIMEOUT_RESET;
      phase           <= PH_IDLE;
      byte_counter    <= 16'd0;
      retry_counter   <= 16'd0;
      command_shift   <= 48'd0;
      current_command <= CMD0;
      pending_request <= OP_INIT;
      saved_address   <= 32'd0;
      card_kind       <= CARD_NONE;
      last_error      <= ST_OK;
      owr             <= 1'b0;
      ord             <= 1'b0;
      ocount          <= 2'd0;
    end else begin
      if (cfg_we) timeout_limit <= cfg_wdata;
      if (item_take) begin
        phase           <= phase_next;
        byte_counter    <= byte_counter_next;
        retry_counter   <= retry_counter_next;
        command_shift   <= command_shift_next;
        current_command <= current_command_next;
        pending_request <= pending_request_next;
        saved_address   <= saved_address_next;
        card_kind       <= card_kind_next;
        last_error      <= last_error_next;
      end
      if (opush) owr <= ~owr;
      if (opop) ord <= ~ord;
      ocount <= ocount + {1'b0, opush} - {1'b0, opop};
    end
  end

endmodule

@@ design/sd_spi_host_sequencer_core.sv @@
// sd card spi-mode host sequencer, top level
// depends on sdsq_pkg, sdsq_front, sdsq_back
//
// input channel: push/full queue; one beat is either a request (init, block read,
// block write) or the report of one exchanged spi byte with rx_byte/write_byte.
// result channel: empty/pop queue; every input beat yields exactly one result beat
// with the next byte to shift, chip select, read data and done/status/card type.
// config: cfg_we/cfg_wdata write timeout_limit (reset 1000), write only while idle.
// a result passes through the front queue, then the sequencer decision is registered
// into the result queue, where it becomes poppable.
// throughput: one beat per cycle while the result queue has room.
// both queues hold two beats; when pop stays low the result queue fills, the
// sequencer stops taking from the front queue, and full rises once that queue holds two.
// reset: synchronous, clears both queues, sequencer idle, card type none, status ok.
module sd_spi_host_sequencer_core import sdsq_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int BUSY_POLL_LIMIT = BUSY_POLL_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [31:0] block_address,
  input  logic        link_timed_out,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  write_byte,
  output logic        empty,
  input  logic        pop,
  output logic        transfer_request,
  output logic [7:0]  tx_byte,
  output logic        chip_select_low,
  output logic        link_init,
  output logic        write_byte_taken,
  output logic        read_valid,
  output logic [7:0]  read_byte,
  output logic        done_res,
  output logic [3:0]  status,
  output logic [1:0]  card_type,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic    item_valid, item_take, res_valid;
  item_t   item;
  result_t res;

  sdsq_front u_front (
    .clk, .rst, .push, .full, .opcode, .block_address, .link_timed_out,
    .rx_byte, .write_byte, .item_valid, .item, .item_take
  );

  sdsq_back #(.BLOCK_BYTES(BLOCK_BYTES), .BUSY_POLL_LIMIT(BUSY_POLL_LIMIT)) u_back (
    .clk, .rst, .cfg_we, .cfg_wdata, .item_valid, .item, .item_take,
    .res_valid, .res, .res_take(pop)
  );

  assign empty            = !res_valid;
  assign transfer_request = res.transfer_request;
  assign tx_byte          = res.tx_byte;
  assign chip_select_low  = res.transfer_request;
  assign link_init        = res.link_init;
  assign write_byte_taken = res.write_byte_taken;
  assign read_valid       = res.read_valid;
  assign read_byte        = res.read_byte;
  assign done_res         = res.done_res;
  assign status           = res.status;
  assign card_type        = res.card_type;

endmodule

@@ design/sdsq_checker.sv @@
// port-level checker for the sequencer core and its bind
// depends on sd_spi_host_sequencer_core ports only
module sdsq_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       transfer_request,
  input logic [7:0] tx_byte,
  input logic       chip_select_low,
  input logic       done_res,
  input logic       read_valid,
  input logic [7:0] read_byte,
  input logic       write_byte_taken
);

  a_cs_tracks_xfer: assert property (@(posedge clk) disable iff (rst)
    !empty |-> chip_select_low == transfer_request)
    else $error("chip select differs from transfer request");

  a_done_no_xfer: assert property (@(posedge clk) disable iff (rst)
    (!empty && done_res) |-> !transfer_request && tx_byte == 8'hFF)
    else $error("done beat asks for a transfer");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !read_valid) |-> read_byte == 8'h00)
    else $error("read byte set without read valid");

  a_wr_xfer: assert property (@(posedge clk) disable iff (rst)
    (!empty && write_byte_taken) |-> transfer_request && !read_valid)
    else $error("write byte taken without transfer");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(tx_byte))
    else $error("stalled result beat changed");

endmodule

bind sd_spi_host_sequencer_core sdsq_checker u_checker (
  .clk, .rst, .empty, .pop, .transfer_request, .tx_byte, .chip_select_low,
  .done_res, .read_valid, .read_byte, .write_byte_taken
);
